### design/calendar_date_add_and_difference_defines.svh
// Assertion macros shared by the date arithmetic block.
// CDAD_ASSERT checks a property on every rising edge outside reset.
// CDAD_NEVER checks that a condition never holds outside reset.
`ifndef CALENDAR_DATE_ADD_AND_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DATE_ADD_AND_DIFFERENCE_DEFINES_SVH
`ifndef SYNTH
`define CDAD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define CDAD_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define CDAD_ASSERT(lbl, clk, rst_n, prop)
`define CDAD_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### design/cdad_pkg.sv
`timescale 1ns / 1ps
package cdad_pkg;

	// Division by 25 as a multiply by a scaled reciprocal, exact below 2^20.
	localparam int DIV25_MUL   = 671089;
	localparam int DIV25_SHIFT = 24;

	// Scaled reciprocal of the mean Gregorian year length, for the year estimate.
	localparam int YRECIP_MUL   = 11759221;
	localparam int YRECIP_SHIFT = 32;

	localparam int DAYS_PER_YEAR = 365;
	localparam int MONTHS        = 12;

	// Cycles from a new year number at the year unit to its registered result.
	localparam int UNIT_LAT = 2;

	// Range of the 23-bit signed day difference.
	localparam int DIFF_W   = 23;
	localparam int DIFF_MIN = -4194304;
	localparam int DIFF_MAX = 4194303;

	typedef logic [3:0] month_t;
	typedef logic [4:0] day_t;

	function automatic day_t month_days(input month_t m, input logic leap);
		day_t len;
		case (m)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

	// Days in the year before the first of month m.
	function automatic logic [8:0] cum_days(input month_t m, input logic leap);
		logic [8:0] c;
		case (m)
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		if (leap && (m > 4'd2)) begin
			c = c + 9'd1;
		end
		return c;
	endfunction

endpackage

### design/cdad_year_unit.sv
`timescale 1ns / 1ps
// Two-stage unit: for n whole years elapsed, gives the serial day of January 1
// of year n+1 and whether year n+1 is a leap year.
module cdad_year_unit import cdad_pkg::*; #(
	parameter int YB = 15,
	parameter int SB = 22
) (
	input  logic          clk,
	input  logic [YB-1:0] n,
	output logic [SB-1:0] ystart,
	output logic          yleap
);

	localparam int PW = YB + DIV25_SHIFT;

	logic [YB-1:0] q4;
	logic [PW-1:0] prod;
	logic [YB-1:0] n_s1;
	logic [YB-1:0] q100_s1;
	logic [YB-1:0] rem100;
	logic [SB-1:0] ystart_s2;
	logic          yleap_s2;

	assign q4   = n >> 2;
	assign prod = PW'(q4) * PW'(DIV25_MUL);

	always_ff @(posedge clk) begin
		n_s1    <= n;
		q100_s1 <= prod[DIV25_SHIFT +: YB];
	end

	assign rem100 = n_s1 - YB'(q100_s1 * YB'(100));

	always_ff @(posedge clk) begin
		ystart_s2 <= SB'(n_s1) * SB'(DAYS_PER_YEAR) + SB'(n_s1 >> 2)
			- SB'(q100_s1) + SB'(q100_s1 >> 2);
		// Year n+1 divisible by 4, 100, 400 is n ending in 3, 99 and 399.
		yleap_s2  <= (n_s1[1:0] == 2'd3)
			&& ((rem100 != YB'(99)) || (q100_s1[1:0] == 2'd3));
	end

	assign ystart = ystart_s2;
	assign yleap  = yleap_s2;

endmodule

### design/calendar_date_add_and_difference.sv
`timescale 1ns / 1ps
// Gregorian date arithmetic. One input word on the s_ channel carries two dates
// A and B, a signed day offset and, in s_tuser, the mode: 0 adds the offset to
// A, 1 gives the day count from B to A. One result word leaves on the m_
// channel with the shifted date or the difference, the A<B and A==B flags,
// and in m_tuser the out-of-range flag for a saturated result.
// The block works on one word at a time and drops s_tready from acceptance
// until its result is loaded into the output register. Dates become serial
// day numbers through a shared two-stage year unit. An add then estimates the
// year by one multiply, corrects it with two or three year-unit uses and steps
// through the months one per cycle. s_tready rises together with m_tvalid.
// A result waiting on a stalled receiver does not block the next acceptance,
// but the following result waits in the sequencer until the output register
// frees. Asynchronous reset returns the sequencer to idle and empties the
// output register; nothing needs clearing.
`include "calendar_date_add_and_difference_defines.svh"
module calendar_date_add_and_difference import cdad_pkg::*; #(
	parameter int YEAR_MAX    = 9999,
	parameter int OFFSET_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// year_a[13:0], month_a[17:14], day_a[22:18], offset[46:23],
	// year_b[60:47], month_b[64:61], day_b[69:65], zero fill [71:70]
	input  logic [71:0] s_tdata,
	// mode[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// year_out[13:0], month_out[17:14], day_out[22:18], days_between[45:23],
	// a_less_b[46], a_equal_b[47]
	output logic [47:0] m_tdata,
	// out_of_range[0]
	output logic        m_tuser
);

	// Year counts reach YEAR_MAX+1, serial days about 366 per year.
	localparam int YB  = $clog2(YEAR_MAX + 3);
	localparam int SB  = $clog2(366 * (YEAR_MAX + 2));
	localparam int TW0 = (SB > OFFSET_BITS) ? SB : OFFSET_BITS;
	localparam int TW  = ((TW0 > DIFF_W) ? TW0 : DIFF_W) + 2;
	localparam int EW  = YRECIP_SHIFT + YB;
	// Serial day of the last day of year YEAR_MAX.
	localparam int TOP_SERIAL = 365 * YEAR_MAX + YEAR_MAX / 4 - YEAR_MAX / 100
		+ YEAR_MAX / 400 - 1;
	localparam logic signed [TW-1:0] TOP_S  = TW'(TOP_SERIAL);
	localparam logic signed [TW-1:0] DMIN_S = TW'(DIFF_MIN);
	localparam logic signed [TW-1:0] DMAX_S = TW'(DIFF_MAX);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SA   = 4'd1;
	localparam logic [3:0] ST_SB   = 4'd2;
	localparam logic [3:0] ST_CALC = 4'd3;
	localparam logic [3:0] ST_EST  = 4'd4;
	localparam logic [3:0] ST_HI   = 4'd5;
	localparam logic [3:0] ST_LO   = 4'd6;
	localparam logic [3:0] ST_MON  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]           state_q;
	logic [1:0]           cnt_q;
	logic                 mv_q;
	logic                 mode_q;
	logic [YB-1:0]        ya_q, yb_q;
	month_t               ma_q, mb_q;
	day_t                 da_q, db_q;
	logic signed [TW-1:0] off_q;
	logic signed [TW-1:0] sa_q, sb_q;
	logic [SB-1:0]        t_q;
	logic [YB-1:0]        n_q;
	logic [8:0]           r_q;
	month_t               m_q;
	logic                 leap_q;
	logic                 lt_q, eq_q, oor_q;
	logic [DIFF_W-1:0]    diff_q;
	logic [47:0]          mdata_q;
	logic                 muser_q;

	logic [YB-1:0]        unit_n;
	logic [SB-1:0]        unit_start;
	logic                 unit_leap;
	logic                 unit_done;
	month_t               cur_m;
	day_t                 cur_d;
	logic [TW-1:0]        ser_calc;
	logic signed [TW-1:0] sum_t, diff_t;
	logic [EW-1:0]        est_prod;
	day_t                 mlen;
	logic                 mon_step;
	logic                 hi_up, lo_down;
	logic                 out_free;
	logic [31:0]          off_raw;
	logic [YB-1:0]        yplus;

	function automatic logic [YB-1:0] clamp_year(input logic [13:0] yr);
		logic [31:0] y32;
		y32 = 32'(yr);
		if (y32 == 32'd0) begin
			y32 = 32'd1;
		end else if (y32 > 32'(YEAR_MAX)) begin
			y32 = 32'(YEAR_MAX);
		end
		return YB'(y32);
	endfunction

	function automatic month_t clamp_month(input month_t m);
		month_t r;
		if (m == 4'd0) begin
			r = 4'd1;
		end else if (m > 4'(MONTHS)) begin
			r = 4'(MONTHS);
		end else begin
			r = m;
		end
		return r;
	endfunction

	// The year unit is shared by both date conversions and the year search.
	always_comb begin
		case (state_q)
			ST_SA:   unit_n = YB'(ya_q - 1'b1);
			ST_SB:   unit_n = YB'(yb_q - 1'b1);
			ST_HI:   unit_n = YB'(n_q + 1'b1);
			default: unit_n = n_q;
		endcase
	end

	cdad_year_unit #(
		.YB(YB),
		.SB(SB)
	) u_year (
		.clk    (clk),
		.n      (unit_n),
		.ystart (unit_start),
		.yleap  (unit_leap)
	);

	assign unit_done = (cnt_q == 2'(UNIT_LAT));

	// Serial day of the date being converted: a day of zero or past the
	// month end simply counts on from the first of the month.
	assign cur_m    = (state_q == ST_SB) ? mb_q : ma_q;
	assign cur_d    = (state_q == ST_SB) ? db_q : da_q;
	assign ser_calc = TW'(unit_start) + TW'(cum_days(cur_m, unit_leap))
		+ TW'(cur_d) - TW'(1);

	assign sum_t    = sa_q + off_q;
	assign diff_t   = sa_q - sb_q;
	assign est_prod = EW'(t_q) * EW'(YRECIP_MUL);
	assign hi_up    = (unit_start <= t_q);
	assign lo_down  = (unit_start > t_q);
	assign mlen     = month_days(m_q, leap_q);
	assign mon_step = (m_q != 4'(MONTHS)) && (9'(mlen) <= r_q);
	assign out_free = !mv_q || m_tready;
	assign off_raw  = 32'(s_tdata[46:23]);
	assign yplus    = YB'(n_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 2'd0;
			mv_q    <= 1'b0;
		end else begin
			// The output register is loaded from the done state and emptied
			// when the receiver takes its word.
			if ((state_q == ST_DONE) && out_free) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= 2'd0;
					if (s_tvalid) begin
						state_q <= ST_SA;
					end
				end
				ST_SA, ST_SB: begin
					if (unit_done) begin
						cnt_q   <= 2'd0;
						state_q <= (state_q == ST_SA) ? ST_SB : ST_CALC;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_CALC: begin
					state_q <= mode_q ? ST_DONE : ST_EST;
				end
				ST_EST: begin
					cnt_q   <= 2'd0;
					state_q <= ST_HI;
				end
				ST_HI: begin
					if (unit_done) begin
						cnt_q <= 2'd0;
						if (!hi_up) begin
							state_q <= ST_LO;
						end
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_LO: begin
					if (unit_done) begin
						cnt_q <= 2'd0;
						if (!lo_down) begin
							state_q <= ST_MON;
						end
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_MON: begin
					if (!mon_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					mode_q <= s_tuser;
					ya_q   <= clamp_year(s_tdata[13:0]);
					ma_q   <= clamp_month(s_tdata[17:14]);
					da_q   <= s_tdata[22:18];
					// Only the low OFFSET_BITS bits count, sign-extended.
					off_q  <= TW'($signed(off_raw[OFFSET_BITS-1:0]));
					yb_q   <= clamp_year(s_tdata[60:47]);
					mb_q   <= clamp_month(s_tdata[64:61]);
					db_q   <= s_tdata[69:65];
				end
			end
			ST_SA: begin
				if (unit_done) begin
					sa_q <= ser_calc;
				end
			end
			ST_SB: begin
				if (unit_done) begin
					sb_q <= ser_calc;
				end
			end
			ST_CALC: begin
				lt_q   <= (sa_q < sb_q);
				eq_q   <= (sa_q == sb_q);
				if (mode_q) begin
					if (diff_t < DMIN_S) begin
						diff_q <= DMIN_S[DIFF_W-1:0];
						oor_q  <= 1'b1;
					end else if (diff_t > DMAX_S) begin
						diff_q <= DMAX_S[DIFF_W-1:0];
						oor_q  <= 1'b1;
					end else begin
						diff_q <= diff_t[DIFF_W-1:0];
						oor_q  <= 1'b0;
					end
				end else begin
					diff_q <= '0;
					if (sum_t[TW-1]) begin
						t_q   <= '0;
						oor_q <= 1'b1;
					end else if (sum_t > TOP_S) begin
						t_q   <= SB'(TOP_SERIAL);
						oor_q <= 1'b1;
					end else begin
						t_q   <= sum_t[SB-1:0];
						oor_q <= 1'b0;
					end
				end
			end
			ST_EST: begin
				// Estimate of whole years before t, off by at most one.
				n_q <= est_prod[YRECIP_SHIFT +: YB];
			end
			ST_HI: begin
				if (unit_done && hi_up) begin
					n_q <= YB'(n_q + 1'b1);
				end
			end
			ST_LO: begin
				if (unit_done) begin
					if (lo_down) begin
						n_q <= YB'(n_q - 1'b1);
					end else begin
						r_q    <= 9'(t_q - unit_start);
						leap_q <= unit_leap;
						m_q    <= 4'd1;
					end
				end
			end
			ST_MON: begin
				if (mon_step) begin
					r_q <= r_q - 9'(mlen);
					m_q <= m_q + 4'd1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					muser_q <= oor_q;
					if (mode_q) begin
						mdata_q <= {eq_q, lt_q, diff_q, 5'd0, 4'd0, 14'd0};
					end else begin
						mdata_q <= {eq_q, lt_q, {DIFF_W{1'b0}}, 5'(r_q + 9'd1), m_q,
							14'(yplus)};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mv_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;

	`CDAD_ASSERT(a_accept_starts, clk, arst_n,
		(s_tvalid && s_tready) |=> (state_q == ST_SA))
	`CDAD_ASSERT(a_valid_from_done, clk, arst_n,
		$rose(m_tvalid) |-> ($past(state_q) == ST_DONE))
	`CDAD_NEVER(a_month_walk_range, clk, arst_n,
		(state_q == ST_MON) && ((m_q == 4'd0) || (m_q > 4'(MONTHS))))
	`CDAD_NEVER(a_year_search_range, clk, arst_n,
		((state_q == ST_HI) || (state_q == ST_LO)) && (32'(n_q) > 32'(YEAR_MAX)))

endmodule

### sim/calendar_date_add_and_difference_tb.sv
`timescale 1ns / 1ps
module calendar_date_add_and_difference_tb;

	localparam int YEAR_MAX       = 9999;
	localparam int OFFSET_BITS    = 24;
	localparam int YEAR_MONTHS    = 12;
	localparam int SPAN_MIN       = -4194304;
	localparam int SPAN_MAX       = 4194303;
	localparam int RANDOM_WORDS   = 1250;
	localparam int QUIET_WORDS    = 150;
	localparam int TAIL_CYCLES    = 150;
	localparam int STALL_LIMIT    = 4000;
	localparam int REPORT_LIMIT   = 10;

	typedef enum logic {
		MODE_SHIFT = 1'b0,
		MODE_SPAN  = 1'b1
	} date_mode_t;

	typedef struct packed {
		date_mode_t             mode;
		logic [13:0]            year_a;
		logic [3:0]             month_a;
		logic [4:0]             day_a;
		logic [OFFSET_BITS-1:0] offset;
		logic [13:0]            year_b;
		logic [3:0]             month_b;
		logic [4:0]             day_b;
	} date_req_t;

	typedef struct packed {
		logic [13:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [22:0] days_between;
		logic        a_less_b;
		logic        a_equal_b;
		logic        out_of_range;
	} date_res_t;

	typedef struct packed {
		date_req_t req;
		logic      typed;
		date_res_t res;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// year_a, month_a, day_a, offset, year_b, month_b, day_b, zero fill
	logic [71:0] s_tdata;
	// mode
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// year_out, month_out, day_out, days_between, a_less_b, a_equal_b
	logic [47:0] m_tdata;
	// out_of_range
	logic        m_tuser;

	date_res_t     awaited_dates[$];
	directed_row_t directed_rows[$];
	int            date_errors;
	int            results_seen;
	int            calm_words;
	int            stall_cycles;
	bit            quiet_tail;

	calendar_date_add_and_difference #(
		.YEAR_MAX   (YEAR_MAX),
		.OFFSET_BITS(OFFSET_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Calendar arithmetic on serial day numbers, with 0001-01-01 as day zero.
	function automatic bit leap_year(longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint month_length(longint y, int m);
		case (m)
			2: begin
				return leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	// Out-of-range years and months are clamped; the day is simply counted
	// on from the first of the month, so day 0 and February 30 fall outside it.
	function automatic longint serial_day(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy);
		longint y;
		longint n;
		longint s;
		int     m;
		y = yr;
		m = mo;
		if (y < 1) y = 1;
		if (y > YEAR_MAX) y = YEAR_MAX;
		if (m < 1) m = 1;
		if (m > YEAR_MONTHS) m = YEAR_MONTHS;
		n = y - 1;
		s = 365 * n + n / 4 - n / 100 + n / 400;
		for (int i = 1; i < m; i++) s += month_length(y, i);
		return s + longint'(dy) - 1;
	endfunction

	function automatic void serial_to_date(input longint s, output longint y,
			output longint m, output longint d);
		longint eras;
		longint rest;
		longint cents;
		longint quads;
		longint yrs;
		int     i;
		eras = s / 146097;
		rest = s % 146097;
		cents = rest / 36524;
		if (cents == 4) cents = 3;
		rest -= cents * 36524;
		quads = rest / 1461;
		rest = rest % 1461;
		yrs = rest / 365;
		if (yrs == 4) yrs = 3;
		rest -= yrs * 365;
		y = 400 * eras + 100 * cents + 4 * quads + yrs + 1;
		i = 1;
		while (i < YEAR_MONTHS && rest >= month_length(y, i)) begin
			rest -= month_length(y, i);
			i++;
		end
		m = i;
		d = rest + 1;
	endfunction

	function automatic date_res_t compute_date_result(date_req_t q);
		date_res_t r;
		longint    sa;
		longint    sb;
		longint    shift;
		longint    t;
		longint    top;
		longint    y;
		longint    m;
		longint    d;
		r = '0;
		sa = serial_day(q.year_a, q.month_a, q.day_a);
		sb = serial_day(q.year_b, q.month_b, q.day_b);
		shift = $signed(q.offset);
		if (q.mode == MODE_SHIFT) begin
			top = serial_day(14'(YEAR_MAX), 4'd12, 5'd31);
			t = sa + shift;
			// A shifted date outside the calendar saturates to its first or last day.
			if (t < 0) begin
				t = 0;
				r.out_of_range = 1'b1;
			end
			if (t > top) begin
				t = top;
				r.out_of_range = 1'b1;
			end
			serial_to_date(t, y, m, d);
			r.year_out = 14'(y);
			r.month_out = 4'(m);
			r.day_out = 5'(d);
		end else begin
			t = sa - sb;
			if (t < SPAN_MIN) begin
				t = SPAN_MIN;
				r.out_of_range = 1'b1;
			end
			if (t > SPAN_MAX) begin
				t = SPAN_MAX;
				r.out_of_range = 1'b1;
			end
			r.days_between = 23'(t);
		end
		r.a_less_b = (sa < sb);
		r.a_equal_b = (sa == sb);
		return r;
	endfunction

	function automatic date_req_t req_word(date_mode_t mode, int ya, int ma, int da, int off,
			int yb, int mb, int db);
		date_req_t q;
		q.mode = mode;
		q.year_a = 14'(ya);
		q.month_a = 4'(ma);
		q.day_a = 5'(da);
		q.offset = OFFSET_BITS'(off);
		q.year_b = 14'(yb);
		q.month_b = 4'(mb);
		q.day_b = 5'(db);
		return q;
	endfunction

	function automatic directed_row_t typed_row(date_req_t q, int yo, int mo, int dout, int span,
			bit lt, bit eq, bit oor);
		directed_row_t row;
		row.req = q;
		row.typed = 1'b1;
		row.res.year_out = 14'(yo);
		row.res.month_out = 4'(mo);
		row.res.day_out = 5'(dout);
		row.res.days_between = 23'(span);
		row.res.a_less_b = lt;
		row.res.a_equal_b = eq;
		row.res.out_of_range = oor;
		return row;
	endfunction

	function automatic directed_row_t predicted_row(date_req_t q);
		directed_row_t row;
		row.req = q;
		row.typed = 1'b0;
		row.res = '0;
		return row;
	endfunction

	// Years lean toward the ends of the calendar and toward century years,
	// where the leap rule has its exceptions.
	function automatic logic [13:0] pick_year();
		case ($urandom_range(0, 7))
			0: begin
				return 14'($urandom_range(1, 4));
			end
			1: begin
				return 14'($urandom_range(YEAR_MAX - 3, YEAR_MAX));
			end
			2: begin
				return 14'(100 * $urandom_range(1, 99) + $urandom_range(0, 1));
			end
			default: begin
				return 14'($urandom_range(1, YEAR_MAX));
			end
		endcase
	endfunction

	function automatic logic [4:0] pick_day(logic [13:0] y, logic [3:0] m);
		int len;
		len = int'(month_length(y, m));
		if ($urandom_range(0, 3) == 0) begin
			return 5'(len - int'($urandom_range(0, 2)));
		end
		return 5'($urandom_range(1, len));
	endfunction

	function automatic date_req_t random_request();
		date_req_t q;
		longint    sa;
		longint    top;
		int        off;
		int        sign;
		q.mode = date_mode_t'($urandom_range(0, 1));
		// Now and then a word with every field drawn over its full width: years 0
		// and above the maximum, months 0 and 13 to 15, day 0.
		if ($urandom_range(0, 9) == 0) begin
			q.year_a = 14'($urandom);
			q.month_a = 4'($urandom);
			q.day_a = 5'($urandom);
			q.offset = OFFSET_BITS'($urandom);
			q.year_b = 14'($urandom);
			q.month_b = 4'($urandom);
			q.day_b = 5'($urandom);
			return q;
		end
		q.year_a = pick_year();
		q.month_a = 4'($urandom_range(1, YEAR_MONTHS));
		q.day_a = pick_day(q.year_a, q.month_a);
		case ($urandom_range(0, 4))
			0: begin
				q.year_b = q.year_a;
				q.month_b = q.month_a;
				q.day_b = q.day_a;
			end
			1: begin
				q.year_b = q.year_a;
				q.month_b = q.month_a;
				q.day_b = 5'(int'(q.day_a) + int'($urandom_range(0, 2)) - 1);
			end
			default: begin
				q.year_b = pick_year();
				q.month_b = 4'($urandom_range(1, YEAR_MONTHS));
				q.day_b = pick_day(q.year_b, q.month_b);
			end
		endcase
		sa = serial_day(q.year_a, q.month_a, q.day_a);
		top = serial_day(14'(YEAR_MAX), 4'd12, 5'd31);
		sign = $urandom_range(0, 1) ? 1 : -1;
		case ($urandom_range(0, 6))
			0: begin
				off = int'($urandom_range(0, 64)) - 32;
			end
			1: begin
				off = sign * int'($urandom_range(0, 1500));
			end
			2: begin
				off = sign * int'($urandom_range(0, 400000));
			end
			3: begin
				off = sign * int'($urandom_range(0, 4000000));
			end
			4: begin
				// Land on the first day of the calendar or within three days of it, on either side.
				off = -int'(sa) + int'($urandom_range(0, 6)) - 3;
			end
			5: begin
				// Land on the last day of the calendar or within three days of it, on either side.
				off = int'(top - sa) + int'($urandom_range(0, 6)) - 3;
			end
			default: begin
				off = int'($urandom);
			end
		endcase
		q.offset = OFFSET_BITS'(off);
		return q;
	endfunction

	// Drives one word from a falling edge and holds it until the block takes it.
	// Gaps come in bursts, with calm stretches of back-to-back words in between.
	task automatic send_word(date_req_t q, logic typed, date_res_t known);
		if (!quiet_tail) begin
			if (calm_words > 0) begin
				calm_words--;
			end else if ($urandom_range(0, 5) == 0) begin
				calm_words = $urandom_range(10, 40);
			end else if ($urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= q.mode;
		s_tdata <= {2'b00, q.day_b, q.month_b, q.year_b, q.offset, q.day_a, q.month_a, q.year_a};
		do @(posedge clk); while (!s_tready);
		awaited_dates.push_back(typed ? known : compute_date_result(q));
		@(negedge clk);
	endtask

	// Lowers valid and holds off until every result in flight has come back.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_dates.size() != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		quiet_tail = 1'b0;
		calm_words = 0;

		// Extremes, saturation, the January borrow, out-of-range fields and
		// overlong days are typed in; the rest go through the predictor.
		directed_rows.push_back(typed_row(req_word(MODE_SHIFT, 2000, 1, 1, 0, 2000, 1, 1),
			2000, 1, 1, 0, 0, 1, 0));
		directed_rows.push_back(typed_row(req_word(MODE_SHIFT, 1, 1, 1, -1, 1, 1, 1),
			1, 1, 1, 0, 0, 1, 1));
		directed_rows.push_back(typed_row(req_word(MODE_SHIFT, 9999, 12, 31, 1, 9999, 12, 31),
			9999, 12, 31, 0, 0, 1, 1));
		directed_rows.push_back(typed_row(req_word(MODE_SHIFT, 2000, 6, 15, 8388607, 2000, 6, 15),
			9999, 12, 31, 0, 0, 1, 1));
		directed_rows.push_back(typed_row(req_word(MODE_SHIFT, 2000, 6, 15, -8388608, 2000, 6, 15),
			1, 1, 1, 0, 0, 1, 1));
		directed_rows.push_back(typed_row(req_word(MODE_SHIFT, 2001, 1, 1, -1, 2001, 1, 1),
			2000, 12, 31, 0, 0, 1, 0));
		directed_rows.push_back(typed_row(req_word(MODE_SHIFT, 2023, 2, 30, 0, 2023, 3, 2),
			2023, 3, 2, 0, 0, 1, 0));
		directed_rows.push_back(typed_row(req_word(MODE_SHIFT, 2024, 3, 0, 0, 2024, 2, 29),
			2024, 2, 29, 0, 0, 1, 0));
		directed_rows.push_back(typed_row(req_word(MODE_SPAN, 2000, 3, 1, 0, 2000, 2, 28),
			0, 0, 0, 2, 0, 0, 0));
		directed_rows.push_back(typed_row(req_word(MODE_SPAN, 1900, 3, 1, 0, 1900, 2, 28),
			0, 0, 0, 1, 0, 0, 0));
		directed_rows.push_back(typed_row(req_word(MODE_SPAN, 2000, 2, 28, 0, 2000, 3, 1),
			0, 0, 0, -2, 1, 0, 0));
		directed_rows.push_back(typed_row(req_word(MODE_SPAN, 0, 0, 1, 0, 1, 1, 1),
			0, 0, 0, 0, 0, 1, 0));
		directed_rows.push_back(typed_row(req_word(MODE_SPAN, 16383, 15, 31, 0, 9999, 12, 31),
			0, 0, 0, 0, 0, 1, 0));
		directed_rows.push_back(predicted_row(req_word(MODE_SPAN, 9999, 12, 31, 0, 1, 1, 1)));
		directed_rows.push_back(predicted_row(req_word(MODE_SPAN, 1, 1, 1, 0, 9999, 12, 31)));
		directed_rows.push_back(predicted_row(req_word(MODE_SHIFT, 0, 0, 0, 0, 1, 1, 1)));
		directed_rows.push_back(predicted_row(req_word(MODE_SHIFT, 2024, 2, 29, 365, 2025, 2, 28)));
		directed_rows.push_back(predicted_row(req_word(MODE_SHIFT, 1900, 2, 28, 1, 1900, 3, 1)));
		directed_rows.push_back(predicted_row(req_word(MODE_SHIFT, 2000, 12, 31, 1, 2000, 1, 1)));
		directed_rows.push_back(predicted_row(req_word(MODE_SHIFT, 1600, 3, 1, -1, 1600, 2, 29)));
		directed_rows.push_back(predicted_row(req_word(MODE_SHIFT, 9999, 12, 31, -3652058, 1, 1, 1)));
		directed_rows.push_back(predicted_row(req_word(MODE_SHIFT, 1, 1, 1, 3652058, 9999, 12, 31)));
		directed_rows.push_back(predicted_row(req_word(MODE_SPAN, 2024, 1, 31, 12345, 2024, 2, 1)));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
		end
		hold_until_drained();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2) begin
				hold_until_drained();
			end
			quiet_tail = (i >= RANDOM_WORDS - QUIET_WORDS);
			send_word(random_request(), 1'b0, '0);
		end
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (date_errors == 0 && awaited_dates.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Receiver: ready in random stretches, some long, broken by stalls; steady
	// ready once the quiet tail starts.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_tready <= 1'b1;
			if (quiet_tail) begin
				@(negedge clk);
			end else begin
				repeat (($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
						: $urandom_range(1, 12)) @(negedge clk);
				if (!quiet_tail) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 18)) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : date_result_check
		date_res_t got;
		date_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.year_out = m_tdata[13:0];
			got.month_out = m_tdata[17:14];
			got.day_out = m_tdata[22:18];
			got.days_between = m_tdata[45:23];
			got.a_less_b = m_tdata[46];
			got.a_equal_b = m_tdata[47];
			got.out_of_range = m_tuser;
			results_seen++;
			if (awaited_dates.size() == 0) begin
				date_errors++;
				if (date_errors <= REPORT_LIMIT) begin
					$display("Result %0d arrived with no word outstanding: %p", results_seen, got);
				end
			end else begin
				want = awaited_dates.pop_front();
				if (got.year_out !== want.year_out || got.month_out !== want.month_out
						|| got.day_out !== want.day_out
						|| got.days_between !== want.days_between
						|| got.a_less_b !== want.a_less_b || got.a_equal_b !== want.a_equal_b
						|| got.out_of_range !== want.out_of_range) begin
					date_errors++;
					if (date_errors <= REPORT_LIMIT) begin
						$display("Result %0d mismatch: expected %0d-%0d-%0d span %0d lt %b eq %b oor %b",
							results_seen, want.year_out, want.month_out, want.day_out,
							$signed(want.days_between), want.a_less_b, want.a_equal_b,
							want.out_of_range);
						$display("  got %0d-%0d-%0d span %0d lt %b eq %b oor %b",
							got.year_out, got.month_out, got.day_out, $signed(got.days_between),
							got.a_less_b, got.a_equal_b, got.out_of_range);
					end
				end
			end
		end
	end

	// A long run of cycles with no word moving on either side means a hang.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
